// ===== rtl/pool_allocator_ordered_list_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pool allocator
// Concurrent assertion wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef POOL_ALLOCATOR_ORDERED_LIST_TOP_MACROS_SVH
`define POOL_ALLOCATOR_ORDERED_LIST_TOP_MACROS_SVH

// A condition that holds at every clock edge outside of reset.
`define PAOL_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that, once seen, implies another in the next cycle.
`define PAOL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/paol_pkg.sv =====
// ----------------------------------------------------------------------------
// Pool allocator package
// Request codes, controller states and the result record.
// ----------------------------------------------------------------------------
package paol_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_FIND    = 2'd2,
    OP_LIST    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALC_WR1,
    S_ALC_WR2,
    S_REL_CHK,
    S_REL_WALK,
    S_REL_WR2,
    S_FIND_CHK,
    S_LIST,
    S_RESP
  } state_e;

  localparam logic RES_OK   = 1'b0;
  localparam logic RES_FAIL = 1'b1;

  typedef struct packed {
    logic       status;
    logic [4:0] id;
    logic       last;
  } res_t;

endpackage

// ===== rtl/paol_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module paol_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pool_allocator_ordered_list_top.sv =====
// ----------------------------------------------------------------------------
// Pool allocator with ordered in-use list
// Free-list allocator whose links live in a RAM, with in-use flags in a second RAM.
// ----------------------------------------------------------------------------
// One request is processed at a time. Allocate takes the free-list head, marks it in use
// and appends it to the tail of the in-use list; it fails without touching the lists when
// the pool is empty. Find checks the in-use flag. Release checks the flag, walks the
// in-use list up to the released entry, unlinks it and pushes it onto the free list; it
// fails when the id is not in use. List returns one result per in-use entry, or a single
// failing result when nothing is in use. The link RAM is read once per cycle as the
// controller follows the lists, except while a list waits on a stalled output. A new
// request is accepted while the previous result still waits in the output register.
// Both RAMs start out with their reset contents through per-entry written flags, so no
// clearing pass is needed after reset.
`include "pool_allocator_ordered_list_top_macros.svh"

module pool_allocator_ordered_list_top #(
  parameter int POOL_SIZE = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [4:0] entry_index, [7:5] zero
  input  logic [1:0] s_axis_tuser_i,   // [1:0] op
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [4:0] entry_id, [7:5] zero
  output logic       m_axis_tuser_o,   // [0] status
  output logic       m_axis_tlast_o
);

  import paol_pkg::*;

  localparam int PW = $clog2(POOL_SIZE + 1);
  localparam int IW = $clog2(POOL_SIZE);
  localparam logic [PW-1:0] NIL    = PW'(POOL_SIZE);
  localparam logic [PW-1:0] LAST_N = PW'(POOL_SIZE - 1);

  state_e          state_q, state_d;
  logic [4:0]      idx_q, idx_d;
  logic [PW-1:0]   cur_q, cur_d;
  logic [PW-1:0]   prev_q, prev_d;
  logic [PW-1:0]   cnt_q, cnt_d;
  logic [PW-1:0]   free_head_q, free_head_d;
  logic [PW-1:0]   used_head_q, used_head_d;
  logic [PW-1:0]   used_tail_q, used_tail_d;
  res_t            res_q, res_d;
  res_t            out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic [POOL_SIZE-1:0] link_vld_q;
  logic [POOL_SIZE-1:0] use_vld_q;
  logic [IW-1:0]        link_ra_q;
  logic                 link_rv_q;
  logic                 use_rv_q;

  logic          link_we;
  logic [IW-1:0] link_waddr;
  logic [PW-1:0] link_wdata;
  logic [IW-1:0] link_raddr;
  logic [PW-1:0] link_ram_rdata;
  logic [PW-1:0] link_nx;
  logic          use_we;
  logic [IW-1:0] use_waddr;
  logic          use_wdata;
  logic [IW-1:0] use_raddr;
  logic          use_ram_rdata;
  logic          use_rdata;

  logic          in_fire;
  logic          out_free;
  op_e           in_op;
  logic [PW-1:0] idx_ptr;
  logic          idx_ok;
  logic          walk_hit;
  logic          walk_end;
  logic          list_fin;

  paol_ram #(
    .WIDTH (PW),
    .DEPTH (POOL_SIZE)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_ram_rdata)
  );

  paol_ram #(
    .WIDTH (1),
    .DEPTH (POOL_SIZE)
  ) u_use_ram (
    .clk_i   (clk_i),
    .we_i    (use_we),
    .waddr_i (use_waddr),
    .wdata_i (use_wdata),
    .raddr_i (use_raddr),
    .rdata_o (use_ram_rdata)
  );

  // An entry never written reads as its reset link, the next entry in order.
  assign link_nx   = link_rv_q ? link_ram_rdata : (PW'(link_ra_q) + PW'(1));
  assign use_rdata = use_rv_q & use_ram_rdata;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign in_op    = op_e'(s_axis_tuser_i);
  assign idx_ptr  = PW'(idx_q);
  assign idx_ok   = int'(idx_q) < POOL_SIZE;
  assign walk_hit = cur_q == idx_ptr;
  assign walk_end = (cur_q >= NIL) || (cnt_q == NIL);
  assign list_fin = (link_nx >= NIL) || (cnt_q == LAST_N);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_ALLOC:   state_d = (free_head_q == NIL) ? S_RESP : S_ALC_WR1;
            OP_RELEASE: state_d = S_REL_CHK;
            OP_FIND:    state_d = S_FIND_CHK;
            OP_LIST:    state_d = (used_head_q == NIL) ? S_RESP : S_LIST;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_ALC_WR1:  state_d = S_ALC_WR2;
      S_ALC_WR2:  state_d = S_RESP;
      S_REL_CHK:  state_d = (idx_ok && use_rdata) ? S_REL_WALK : S_RESP;
      S_REL_WALK: begin
        if (walk_hit) begin
          state_d = S_REL_WR2;
        end else if (walk_end) begin
          state_d = S_RESP;
        end
      end
      S_REL_WR2:  state_d = S_RESP;
      S_FIND_CHK: state_d = S_RESP;
      S_LIST: begin
        if (out_free && list_fin) begin
          state_d = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    cnt_d       = cnt_q;
    free_head_d = free_head_q;
    used_head_d = used_head_q;
    used_tail_d = used_tail_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    link_we     = 1'b0;
    link_waddr  = IW'(cur_q);
    link_wdata  = NIL;
    link_raddr  = IW'(cur_q);
    use_we      = 1'b0;
    use_waddr   = IW'(idx_q);
    use_wdata   = 1'b0;
    use_raddr   = IW'(idx_q);
    s_axis_tready_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        idx_d     = s_axis_tdata_i[4:0];
        use_raddr = IW'(s_axis_tdata_i[4:0]);
        res_d     = '{status: RES_FAIL, id: 5'd0, last: 1'b1};
        cnt_d     = '0;
        if (in_op == OP_LIST) begin
          link_raddr = IW'(used_head_q);
          cur_d      = used_head_q;
        end else begin
          link_raddr = IW'(free_head_q);
          cur_d      = free_head_q;
        end
      end
      S_ALC_WR1: begin
        free_head_d = link_nx;
        link_we     = 1'b1;
        link_waddr  = IW'(cur_q);
        link_wdata  = NIL;
        use_we      = 1'b1;
        use_waddr   = IW'(cur_q);
        use_wdata   = 1'b1;
      end
      S_ALC_WR2: begin
        if (used_tail_q != NIL) begin
          link_we    = 1'b1;
          link_waddr = IW'(used_tail_q);
          link_wdata = cur_q;
        end else begin
          used_head_d = cur_q;
        end
        used_tail_d = cur_q;
        res_d       = '{status: RES_OK, id: 5'(cur_q), last: 1'b1};
      end
      S_REL_CHK: begin
        cur_d      = used_head_q;
        prev_d     = NIL;
        cnt_d      = '0;
        link_raddr = IW'(used_head_q);
        res_d      = '{status: RES_FAIL, id: idx_q, last: 1'b1};
      end
      S_REL_WALK: begin
        if (walk_hit) begin
          if (prev_q != NIL) begin
            link_we    = 1'b1;
            link_waddr = IW'(prev_q);
            link_wdata = link_nx;
          end else begin
            used_head_d = link_nx;
          end
          if (used_tail_q == cur_q) begin
            used_tail_d = prev_q;
          end
          use_we    = 1'b1;
          use_waddr = IW'(idx_q);
          use_wdata = 1'b0;
        end else if (!walk_end) begin
          prev_d     = cur_q;
          cur_d      = link_nx;
          cnt_d      = cnt_q + PW'(1);
          link_raddr = IW'(link_nx);
        end
      end
      S_REL_WR2: begin
        link_we     = 1'b1;
        link_waddr  = IW'(idx_q);
        link_wdata  = free_head_q;
        free_head_d = idx_ptr;
        res_d       = '{status: RES_OK, id: idx_q, last: 1'b1};
      end
      S_FIND_CHK: begin
        res_d = '{status: (idx_ok && use_rdata) ? RES_OK : RES_FAIL, id: idx_q, last: 1'b1};
      end
      S_LIST: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{status: RES_OK, id: 5'(cur_q), last: list_fin};
          cur_d       = link_nx;
          cnt_d       = cnt_q + PW'(1);
          link_raddr  = IW'(link_nx);
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      used_head_q <= NIL;
      used_tail_q <= NIL;
      out_valid_q <= 1'b0;
      link_vld_q  <= '0;
      use_vld_q   <= '0;
      link_rv_q   <= 1'b0;
      use_rv_q    <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      used_head_q <= used_head_d;
      used_tail_q <= used_tail_d;
      out_valid_q <= out_valid_d;
      link_rv_q   <= link_vld_q[link_raddr];
      use_rv_q    <= use_vld_q[use_raddr];
      cnt_q       <= cnt_d;
      if (link_we) begin
        link_vld_q[link_waddr] <= 1'b1;
      end
      if (use_we) begin
        use_vld_q[use_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    res_q     <= res_d;
    out_q     <= out_d;
    link_ra_q <= link_raddr;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q.id};
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tlast_o  = out_q.last;

  `PAOL_ASSERT(a_ptr_range, (free_head_q <= NIL) && (used_head_q <= NIL) && (used_tail_q <= NIL), "list pointer out of range")
  `PAOL_ASSERT(a_ends_agree, (used_head_q == NIL) == (used_tail_q == NIL), "in-use list ends disagree")
  `PAOL_ASSERT(a_walk_bound, cnt_q <= NIL, "list walk ran past the pool size")
  `PAOL_ASSERT_NEXT(a_list_done, (state_q == S_LIST) && out_free && list_fin, state_q == S_IDLE, "list did not finish after its last result")

endmodule
